// File: hdl/mer_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mer_pkg;

  // field widths
  localparam int RADIUS_BITS = 10;
  localparam int COORD_BITS  = 12;
  localparam int OFF_W       = COORD_BITS - 1;

  // datapath widths
  localparam int SQ_W     = 2 * RADIUS_BITS;
  localparam int SLOPE_W  = SQ_W + OFF_W + 3;
  localparam int DEC_W    = SQ_W + 2 * OFF_W + 6;
  localparam int MUL_A_W  = SQ_W + OFF_W + 1;
  localparam int MUL_B_W  = (SQ_W > OFF_W + 1) ? SQ_W : OFF_W + 1;
  localparam int PROD_W   = MUL_A_W + MUL_B_W;

  // micro program counter and entry points
  localparam int UPC_W = 4;
  typedef logic [UPC_W-1:0] upc_t;

  localparam upc_t UPC_FETCH  = 4'd0;
  localparam upc_t UPC_SETUP  = 4'd1;
  localparam upc_t UPC_R1     = 4'd5;
  localparam upc_t UPC_SWITCH = 4'd7;
  localparam upc_t UPC_R2     = 4'd13;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_ONE,
    PH_TWO
  } phase_e;

  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_RX_RX,
    MUL_RY_RY,
    MUL_RX2_RY,
    MUL_RY2_TX,
    MUL_P_TX,
    MUL_RX2_TY,
    MUL_P_TY,
    MUL_RX2_RY2
  } mul_sel_e;

  typedef enum logic [1:0] {
    WB_NONE,
    WB_RX2,
    WB_RY2,
    WB_STY
  } wb_sel_e;

  typedef enum logic [2:0] {
    DEC_HOLD,
    DEC_LD_P,
    DEC_ADD_4P,
    DEC_SUB_4P,
    DEC_STEP
  } dec_op_e;

  typedef enum logic [1:0] {
    WALK_NONE,
    WALK_R1_MOVE,
    WALK_R2_MOVE
  } walk_op_e;

  typedef enum logic [1:0] {
    COND_NEXT,
    COND_JUMP,
    COND_Y_ZERO,
    COND_DISPATCH
  } cond_e;

  // one control word of the micro program
  typedef struct packed {
    mul_sel_e msel;
    wb_sel_e  wb;
    dec_op_e  dop;
    walk_op_e wop;
    logic     emit;
    logic     region;
    logic     set_r2;
    cond_e    cond;
    upc_t     target;
  } uword_t;

  // sequencer to datapath
  typedef struct packed {
    logic run;
    logic start;
  } ctrl_t;

  // datapath to sequencer
  typedef struct packed {
    phase_e phase;
    logic   slope_lt;
    logic   y_zero;
    logic   out_busy;
  } stat_t;

endpackage

`default_nettype wire

// File: hdl/midpoint_ellipse_rasterizer.sv
// start request: 4 micro steps on the shared multiplier from accept to next ready
// ordinary step request: add-only; a move-and-emit step, then a decision step; the pixel is registered on the emit step
// step that switches to region two: 5 multiplies build the new decision, then a region two step follows
// results sit in an output register, so the next request is taken while a pixel waits
// reset (rst_ni low, asynchronous) returns the sequencer to fetch, walk to idle, output empty
`timescale 1ns / 1ps
`default_nettype none

module midpoint_ellipse_rasterizer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // request channel
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            cmd_i,
  input  logic [mer_pkg::RADIUS_BITS-1:0] radius_x_i,
  input  logic [mer_pkg::RADIUS_BITS-1:0] radius_y_i,
  input  logic [mer_pkg::OFF_W-1:0]       centre_x_i,
  input  logic [mer_pkg::OFF_W-1:0]       centre_y_i,
  // pixel channel
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [mer_pkg::COORD_BITS-1:0]  pixel_x_o,
  output logic [mer_pkg::COORD_BITS-1:0]  pixel_y_o,
  output logic                            region_o,
  output logic                            last_o
);
  import mer_pkg::*;

  // micro address from the sequencer, control word back from the rom
  upc_t   upc;
  uword_t uword;
  ctrl_t  ctrl;
  stat_t  stat;

  // read-only micro program: setup, region one step, region switch, region two step
  mer_ucode_rom u_rom (
    .upc_i   (upc),
    .uword_o (uword)
  );

  // step counter with dispatch on request type and walk phase;
  // holds on an emit step while the output register is still full
  mer_sequencer u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_i      (cmd_i),
    .uword_i    (uword),
    .stat_i     (stat),
    .upc_o      (upc),
    .ctrl_o     (ctrl)
  );

  // decision terms, offsets, one shared registered multiplier,
  // and the output register that parts the pixel channel from the walk
  mer_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .uword_i     (uword),
    .ctrl_i      (ctrl),
    .radius_x_i  (radius_x_i),
    .radius_y_i  (radius_y_i),
    .centre_x_i  (centre_x_i),
    .centre_y_i  (centre_y_i),
    .out_ready_i (out_ready_i),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .pixel_x_o   (pixel_x_o),
    .pixel_y_o   (pixel_y_o),
    .region_o    (region_o),
    .last_o      (last_o)
  );

endmodule

`default_nettype wire

// File: hdl/mer_ucode_rom.sv
`timescale 1ns / 1ps
`default_nettype none

module mer_ucode_rom (
  input  mer_pkg::upc_t   upc_i,
  output mer_pkg::uword_t uword_o
);
  import mer_pkg::*;

  uword_t uw;

  always_comb begin
    uw        = '0;
    uw.msel   = MUL_NONE;
    uw.wb     = WB_NONE;
    uw.dop    = DEC_HOLD;
    uw.wop    = WALK_NONE;
    uw.cond   = COND_NEXT;
    uw.target = UPC_FETCH;
    case (upc_i)
      UPC_FETCH: begin
        uw.cond = COND_DISPATCH;
      end
      // setup: rx^2, ry^2, slope in y, decision for region one
      UPC_SETUP: begin
        uw.msel = MUL_RX_RX;
      end
      UPC_SETUP + 4'd1: begin
        uw.wb   = WB_RX2;
        uw.msel = MUL_RY_RY;
        uw.dop  = DEC_LD_P;
      end
      UPC_SETUP + 4'd2: begin
        uw.wb   = WB_RY2;
        uw.msel = MUL_RX2_RY;
        uw.dop  = DEC_ADD_4P;
      end
      UPC_SETUP + 4'd3: begin
        uw.wb   = WB_STY;
        uw.dop  = DEC_SUB_4P;
        uw.cond = COND_JUMP;
      end
      // region one step
      UPC_R1: begin
        uw.wop  = WALK_R1_MOVE;
        uw.emit = 1'b1;
      end
      UPC_R1 + 4'd1: begin
        uw.dop  = DEC_STEP;
        uw.cond = COND_JUMP;
      end
      // switch to region two: new decision term
      UPC_SWITCH: begin
        uw.msel = MUL_RY2_TX;
      end
      UPC_SWITCH + 4'd1: begin
        uw.msel = MUL_P_TX;
      end
      UPC_SWITCH + 4'd2: begin
        uw.dop  = DEC_LD_P;
        uw.msel = MUL_RX2_TY;
      end
      UPC_SWITCH + 4'd3: begin
        uw.msel = MUL_P_TY;
      end
      UPC_SWITCH + 4'd4: begin
        uw.dop  = DEC_ADD_4P;
        uw.msel = MUL_RX2_RY2;
      end
      UPC_SWITCH + 4'd5: begin
        uw.dop    = DEC_SUB_4P;
        uw.set_r2 = 1'b1;
      end
      // region two step, ends the walk at y zero
      UPC_R2: begin
        uw.wop    = WALK_R2_MOVE;
        uw.emit   = 1'b1;
        uw.region = 1'b1;
        uw.cond   = COND_Y_ZERO;
      end
      UPC_R2 + 4'd1: begin
        uw.dop    = DEC_STEP;
        uw.region = 1'b1;
        uw.cond   = COND_JUMP;
      end
      default: begin
        uw.cond = COND_JUMP;
      end
    endcase
  end

  assign uword_o = uw;

endmodule

`default_nettype wire

// File: hdl/mer_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none

module mer_sequencer (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            cmd_i,
  input  mer_pkg::uword_t uword_i,
  input  mer_pkg::stat_t  stat_i,
  output mer_pkg::upc_t   upc_o,
  output mer_pkg::ctrl_t  ctrl_o
);
  import mer_pkg::*;

  upc_t upc_q, upc_d;
  logic stall;
  logic in_ready;
  logic start;

  // outputs of the sequencer
  always_comb begin
    stall    = uword_i.emit && stat_i.out_busy;
    in_ready = (uword_i.cond == COND_DISPATCH);
    start    = in_valid_i && in_ready && !cmd_i;
  end

  // next micro address
  always_comb begin
    upc_d = upc_q + 4'd1;
    case (uword_i.cond)
      COND_NEXT:   upc_d = upc_q + 4'd1;
      COND_JUMP:   upc_d = uword_i.target;
      COND_Y_ZERO: upc_d = stat_i.y_zero ? uword_i.target : upc_q + 4'd1;
      COND_DISPATCH: begin
        upc_d = UPC_FETCH;
        if (in_valid_i) begin
          if (!cmd_i) begin
            upc_d = UPC_SETUP;
          end else begin
            case (stat_i.phase)
              PH_ONE:  upc_d = stat_i.slope_lt ? UPC_R1 : UPC_SWITCH;
              PH_TWO:  upc_d = UPC_R2;
              default: upc_d = UPC_FETCH;
            endcase
          end
        end
      end
      default: upc_d = UPC_FETCH;
    endcase
    if (stall) begin
      upc_d = upc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= UPC_FETCH;
    end else begin
      upc_q <= upc_d;
    end
  end

  assign upc_o        = upc_q;
  assign in_ready_o   = in_ready;
  assign ctrl_o.run   = !stall;
  assign ctrl_o.start = start;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> upc_q == UPC_SETUP)
    else $error("start request did not enter setup");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall |=> upc_q == $past(upc_q))
    else $error("micro address moved during output stall");

endmodule

`default_nettype wire

// File: hdl/mer_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module mer_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  mer_pkg::uword_t                   uword_i,
  input  mer_pkg::ctrl_t                    ctrl_i,
  input  logic [mer_pkg::RADIUS_BITS-1:0]   radius_x_i,
  input  logic [mer_pkg::RADIUS_BITS-1:0]   radius_y_i,
  input  logic [mer_pkg::OFF_W-1:0]         centre_x_i,
  input  logic [mer_pkg::OFF_W-1:0]         centre_y_i,
  input  logic                              out_ready_i,
  output mer_pkg::stat_t                    stat_o,
  output logic                              out_valid_o,
  output logic [mer_pkg::COORD_BITS-1:0]    pixel_x_o,
  output logic [mer_pkg::COORD_BITS-1:0]    pixel_y_o,
  output logic                              region_o,
  output logic                              last_o
);
  import mer_pkg::*;

  // control state
  phase_e phase_q, phase_d;
  logic   out_valid_q, out_valid_d;

  // payload
  logic [RADIUS_BITS-1:0]    rx_q, rx_d, ry_q, ry_d;
  logic [SQ_W-1:0]           rx2_q, rx2_d, ry2_q, ry2_d;
  logic [OFF_W-1:0]          cx_q, cx_d, cy_q, cy_d;
  logic [OFF_W-1:0]          off_x_q, off_x_d, off_y_q, off_y_d;
  logic signed [SLOPE_W-1:0] stx_q, stx_d, sty_q, sty_d;
  logic signed [DEC_W-1:0]   dec_q, dec_d;
  logic [PROD_W-1:0]         prod_q, prod_d;
  logic [COORD_BITS-1:0]     pix_x_q, pix_x_d, pix_y_q, pix_y_d;
  logic                      region_q, region_d, last_q, last_d;

  logic [MUL_A_W-1:0]        mul_a;
  logic [MUL_B_W-1:0]        mul_b;
  logic [OFF_W:0]            tx;
  logic [OFF_W-1:0]          ty;
  logic signed [SLOPE_W-1:0] two_rx2, two_ry2;
  logic signed [SLOPE_W-1:0] ta, tb;
  logic [SQ_W-1:0]           sq_sel;
  logic [SLOPE_W:0]          step_t;
  logic [DEC_W-1:0]          p_dec, p4;
  logic                      dec_neg, dec_pos, y_zero, emit_fire;

  always_comb begin
    tx        = {off_x_q, 1'b1};
    ty        = (off_y_q == '0) ? OFF_W'(1) : off_y_q - OFF_W'(1);
    two_rx2   = {{(SLOPE_W-SQ_W-1){1'b0}}, rx2_q, 1'b0};
    two_ry2   = {{(SLOPE_W-SQ_W-1){1'b0}}, ry2_q, 1'b0};
    dec_neg   = dec_q[DEC_W-1];
    dec_pos   = !dec_q[DEC_W-1] && (dec_q != '0);
    y_zero    = (off_y_q == '0);
    emit_fire = ctrl_i.run && uword_i.emit;
    p_dec     = prod_q[DEC_W-1:0];
    p4        = {prod_q[DEC_W-3:0], 2'b00};
  end

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (uword_i.msel)
      MUL_RX_RX: begin
        mul_a = MUL_A_W'(rx_q);
        mul_b = MUL_B_W'(rx_q);
      end
      MUL_RY_RY: begin
        mul_a = MUL_A_W'(ry_q);
        mul_b = MUL_B_W'(ry_q);
      end
      MUL_RX2_RY: begin
        mul_a = MUL_A_W'(rx2_q);
        mul_b = MUL_B_W'(ry_q);
      end
      MUL_RY2_TX: begin
        mul_a = MUL_A_W'(ry2_q);
        mul_b = MUL_B_W'(tx);
      end
      MUL_P_TX: begin
        mul_a = prod_q[MUL_A_W-1:0];
        mul_b = MUL_B_W'(tx);
      end
      MUL_RX2_TY: begin
        mul_a = MUL_A_W'(rx2_q);
        mul_b = MUL_B_W'(ty);
      end
      MUL_P_TY: begin
        mul_a = prod_q[MUL_A_W-1:0];
        mul_b = MUL_B_W'(ty);
      end
      MUL_RX2_RY2: begin
        mul_a = MUL_A_W'(rx2_q);
        mul_b = MUL_B_W'(ry2_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // decision step term: region one and region two share one adder
  always_comb begin
    if (uword_i.region) begin
      ta     = dec_pos ? '0 : stx_q;
      tb     = sty_q;
      sq_sel = rx2_q;
    end else begin
      ta     = stx_q;
      tb     = dec_neg ? '0 : sty_q;
      sq_sel = ry2_q;
    end
    step_t = (SLOPE_W+1)'(ta) - (SLOPE_W+1)'(tb) + (SLOPE_W+1)'(sq_sel);
  end

  always_comb begin
    phase_d     = phase_q;
    out_valid_d = out_valid_q && !out_ready_i;
    rx_d        = rx_q;
    ry_d        = ry_q;
    rx2_d       = rx2_q;
    ry2_d       = ry2_q;
    cx_d        = cx_q;
    cy_d        = cy_q;
    off_x_d     = off_x_q;
    off_y_d     = off_y_q;
    stx_d       = stx_q;
    sty_d       = sty_q;
    dec_d       = dec_q;
    prod_d      = prod_q;
    pix_x_d     = pix_x_q;
    pix_y_d     = pix_y_q;
    region_d    = region_q;
    last_d      = last_q;

    if (ctrl_i.start) begin
      rx_d    = radius_x_i;
      ry_d    = radius_y_i;
      cx_d    = centre_x_i;
      cy_d    = centre_y_i;
      off_x_d = '0;
      off_y_d = OFF_W'(radius_y_i);
      stx_d   = '0;
      phase_d = PH_ONE;
    end else if (ctrl_i.run) begin
      if (uword_i.msel != MUL_NONE) begin
        prod_d = PROD_W'(mul_a) * PROD_W'(mul_b);
      end

      case (uword_i.wb)
        WB_RX2:  rx2_d = prod_q[SQ_W-1:0];
        WB_RY2:  ry2_d = prod_q[SQ_W-1:0];
        WB_STY:  sty_d = {1'b0, prod_q[SLOPE_W-3:0], 1'b0};
        default: ;
      endcase

      case (uword_i.dop)
        DEC_LD_P:   dec_d = p_dec;
        DEC_ADD_4P: dec_d = dec_q + $signed(p4);
        DEC_SUB_4P: dec_d = dec_q - $signed(p4);
        DEC_STEP:   dec_d = dec_q + $signed({{(DEC_W-SLOPE_W-3){step_t[SLOPE_W]}},
                                             step_t, 2'b00});
        default:    ;
      endcase

      case (uword_i.wop)
        WALK_R1_MOVE: begin
          off_x_d = off_x_q + OFF_W'(1);
          stx_d   = stx_q + two_ry2;
          if (!dec_neg) begin
            off_y_d = off_y_q - OFF_W'(1);
            sty_d   = sty_q - two_rx2;
          end
        end
        WALK_R2_MOVE: begin
          if (!y_zero) begin
            off_y_d = off_y_q - OFF_W'(1);
            sty_d   = sty_q - two_rx2;
            if (!dec_pos) begin
              off_x_d = off_x_q + OFF_W'(1);
              stx_d   = stx_q + two_ry2;
            end
          end
        end
        default: ;
      endcase

      if (uword_i.set_r2) begin
        phase_d = PH_TWO;
      end

      if (emit_fire) begin
        out_valid_d = 1'b1;
        pix_x_d     = COORD_BITS'(cx_q) + COORD_BITS'(off_x_q);
        pix_y_d     = COORD_BITS'(cy_q) + COORD_BITS'(off_y_q);
        region_d    = uword_i.region;
        last_d      = y_zero;
        if (y_zero) begin
          phase_d = PH_IDLE;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rx_q     <= rx_d;
    ry_q     <= ry_d;
    rx2_q    <= rx2_d;
    ry2_q    <= ry2_d;
    cx_q     <= cx_d;
    cy_q     <= cy_d;
    off_x_q  <= off_x_d;
    off_y_q  <= off_y_d;
    stx_q    <= stx_d;
    sty_q    <= sty_d;
    dec_q    <= dec_d;
    prod_q   <= prod_d;
    pix_x_q  <= pix_x_d;
    pix_y_q  <= pix_y_d;
    region_q <= region_d;
    last_q   <= last_d;
  end

  assign stat_o.phase    = phase_q;
  assign stat_o.slope_lt = (stx_q < sty_q);
  assign stat_o.y_zero   = y_zero;
  assign stat_o.out_busy = out_valid_q && !out_ready_i;

  assign out_valid_o = out_valid_q;
  assign pixel_x_o   = pix_x_q;
  assign pixel_y_o   = pix_y_q;
  assign region_o    = region_q;
  assign last_o      = last_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_fire && !uword_i.region |-> !y_zero)
    else $error("region one pixel emitted with zero y offset");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_fire && y_zero |=> phase_q == PH_IDLE)
    else $error("walk did not end after last pixel");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_fire |-> !out_valid_q || out_ready_i)
    else $error("pixel overwrote an untaken result");

endmodule

`default_nettype wire
